[hdl/hlc_pkg.sv]
`timescale 1ns / 1ps

package hlc_pkg;

    // Field widths
    localparam int TIME_W        = 63;
    localparam int NODE_W        = 16;
    localparam int MSG_LOGICAL_W = 32;
    localparam int COUNT_W       = 16;
    localparam int OUT_LOGICAL_W = 32;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 2;

    localparam int S_TDATA_W = 240;
    localparam int M_TDATA_W = 144;

    localparam int LOGICAL_WIDTH_DEF = 32;

    // Register reset values (microseconds)
    localparam logic [TIME_W-1:0] SKEW_LIMIT_RST    = TIME_W'(5000000);
    localparam logic [TIME_W-1:0] WARN_INTERVAL_RST = TIME_W'(5000000);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOCAL   = 2'd0,
        CMD_MERGE   = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_NONE    = 2'd3
    } hlc_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_STALLED   = 2'd1,
        ST_REJECTED  = 2'd2,
        ST_SATURATED = 2'd3
    } hlc_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_ID       = 2'd0,
        REG_SKEW_LIMIT    = 2'd1,
        REG_WARN_INTERVAL = 2'd2
    } hlc_reg_t;

    // Request payload, first member in the top bits
    typedef struct packed {
        logic [COUNT_W-1:0]       req_count;
        logic [TIME_W-1:0]        req_time;
        logic [MSG_LOGICAL_W-1:0] msg_logical;
        logic [TIME_W-1:0]        msg_wall_time;
        logic [TIME_W-1:0]        phys_time;
    } hlc_req_t;

    // Result payload, wall time in the lowest bits
    typedef struct packed {
        logic [OUT_LOGICAL_W-1:0] first_reserved;
        logic                     skew_warning;
        logic [NODE_W-1:0]        out_node_id;
        logic [OUT_LOGICAL_W-1:0] out_logical;
        logic [TIME_W-1:0]        out_wall_time;
    } hlc_res_t;

    // Skew warning settings seen by the step logic
    typedef struct packed {
        logic [TIME_W-1:0] skew_limit;
        logic [TIME_W-1:0] warn_interval;
    } hlc_cfg_t;

endpackage

[hdl/hlc_step.sv]
`timescale 1ns / 1ps

module hlc_step
    import hlc_pkg::*;
#(
    parameter int LW = LOGICAL_WIDTH_DEF
) (
    input  logic [CMD_W-1:0]  cmd,
    input  hlc_req_t          req,
    input  hlc_cfg_t          cfg,
    input  logic [TIME_W-1:0] wall,
    input  logic [LW-1:0]     logical,
    input  logic [TIME_W-1:0] warn_time,
    output logic [TIME_W-1:0] wall_next,
    output logic [LW-1:0]     logical_next,
    output logic [TIME_W-1:0] warn_time_next,
    output hlc_status_t       status,
    output logic              warn,
    output logic [LW-1:0]     first
);

    localparam logic [LW-1:0] LMAX = {LW{1'b1}};

    logic [TIME_W-1:0] phys, mwall, rtime;
    logic [TIME_W-1:0] lag, since_warn;
    logic              phys_gt_wall, warn_hit;
    logic              l_ge_m, m_ge_l, m_ge_p, eq_l, eq_m;
    logic [LW-1:0]     cmsg, base;
    logic [TIME_W-1:0] merge_wall;
    logic              rsv_reject, rsv_move, rsv_full;
    logic [LW-1:0]     rsv_base, rsv_room;

    assign phys  = req.phys_time;
    assign mwall = req.msg_wall_time;
    assign rtime = req.req_time;

    // Local event: advance test and lag warning
    assign phys_gt_wall = phys > wall;
    assign lag          = wall - phys;
    assign since_warn   = phys - warn_time;
    assign warn_hit     = (lag > cfg.skew_limit) && (phys >= warn_time)
                          && (since_warn > cfg.warn_interval);

    // Merge: max of three from parallel compares
    assign l_ge_m     = wall >= mwall;
    assign m_ge_l     = mwall >= wall;
    assign m_ge_p     = mwall >= phys;
    assign eq_l       = l_ge_m && !phys_gt_wall;
    assign eq_m       = m_ge_l && m_ge_p;
    assign merge_wall = eq_l ? wall : (eq_m ? mwall : phys);
    assign cmsg       = (req.msg_logical > MSG_LOGICAL_W'(LMAX)) ? LMAX
                                                                 : LW'(req.msg_logical);

    always_comb begin
        if (eq_l && eq_m) begin
            base = (logical > cmsg) ? logical : cmsg;
        end else if (eq_l) begin
            base = logical;
        end else begin
            base = cmsg;
        end
    end

    // Reserve: floor check, optional move up to the requested time, room check
    assign rsv_reject = (req.req_count == '0) || (rtime < phys) || (rtime < wall);
    assign rsv_move   = rtime > wall;
    assign rsv_base   = rsv_move ? '0 : logical;
    assign rsv_room   = LMAX - rsv_base;
    assign rsv_full   = 33'(rsv_room) < 33'(req.req_count);

    always_comb begin
        wall_next      = wall;
        logical_next   = logical;
        warn_time_next = warn_time;
        status         = ST_OK;
        warn           = 1'b0;
        first          = '0;
        case (cmd)
            CMD_LOCAL: begin
                if (phys_gt_wall) begin
                    wall_next    = phys;
                    logical_next = '0;
                end else begin
                    if (warn_hit) begin
                        warn           = 1'b1;
                        warn_time_next = phys;
                    end
                    if (logical == LMAX) begin
                        status = ST_STALLED;
                    end else begin
                        logical_next = logical + LW'(1);
                    end
                end
            end
            CMD_MERGE: begin
                wall_next = merge_wall;
                if (!(eq_l || eq_m)) begin
                    logical_next = '0;
                end else if (base == LMAX) begin
                    logical_next = LMAX;
                    status       = ST_SATURATED;
                end else begin
                    logical_next = base + LW'(1);
                end
            end
            CMD_RESERVE: begin
                if (rsv_reject) begin
                    status = ST_REJECTED;
                end else begin
                    if (rsv_move) begin
                        wall_next    = rtime;
                        logical_next = '0;
                    end
                    if (rsv_full) begin
                        status = ST_REJECTED;
                    end else begin
                        first        = rsv_base + LW'(1);
                        logical_next = LW'(33'(rsv_base) + 33'(req.req_count));
                    end
                end
            end
            default: begin
                // unused command: clock echoed unchanged
            end
        endcase
    end

endmodule

[hdl/hybrid_logical_clock_unit.sv]
`timescale 1ns / 1ps
// Hybrid logical clock: one request per clock cycle, sustained while the result channel is ready.
// Path: an accepted request is held in the request register, then one pass of compares and
// increments in hlc_step writes the result register that drives m_.
// The rate is set by the single clock state update per request, computed by hlc_step.
// Reset (aresetn low, synchronous): clock state cleared, registers back to defaults,
// both channels empty.

module hybrid_logical_clock_unit
    import hlc_pkg::*;
#(
    parameter int LOGICAL_WIDTH = LOGICAL_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_W-1:0]     cfg_wdata,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // phys_time, msg_wall_time, msg_logical, req_time, req_count, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic [CMD_W-1:0]      s_tuser,
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_wall_time, out_logical, out_node_id, skew_warning, first_reserved
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [STATUS_W-1:0]   m_tuser
);

    logic                     in_valid_reg;
    hlc_req_t                 in_req_reg;
    logic [CMD_W-1:0]         in_cmd_reg;
    logic                     out_valid_reg;
    hlc_res_t                 out_res_reg;
    hlc_status_t              out_status_reg;

    logic [NODE_W-1:0]        node_id_reg;
    hlc_cfg_t                 cfg_reg;

    logic [TIME_W-1:0]        wall_reg, wall_next;
    logic [LOGICAL_WIDTH-1:0] logical_reg, logical_next;
    logic [TIME_W-1:0]        warn_time_reg, warn_time_next;

    hlc_status_t              step_status;
    logic                     step_warn;
    logic [LOGICAL_WIDTH-1:0] step_first;
    logic                     advance;

    // Pipeline control: a request moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_req_reg <= hlc_req_t'(s_tdata[$bits(hlc_req_t)-1:0]);
            in_cmd_reg <= s_tuser;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg           <= '0;
            cfg_reg.skew_limit    <= SKEW_LIMIT_RST;
            cfg_reg.warn_interval <= WARN_INTERVAL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NODE_ID:       node_id_reg           <= cfg_wdata[NODE_W-1:0];
                REG_SKEW_LIMIT:    cfg_reg.skew_limit    <= cfg_wdata;
                REG_WARN_INTERVAL: cfg_reg.warn_interval <= cfg_wdata;
                default: begin
                    // index beyond the register list: ignored
                end
            endcase
        end
    end

    hlc_step #(
        .LW(LOGICAL_WIDTH)
    ) u_step (
        .cmd            (in_cmd_reg),
        .req            (in_req_reg),
        .cfg            (cfg_reg),
        .wall           (wall_reg),
        .logical        (logical_reg),
        .warn_time      (warn_time_reg),
        .wall_next      (wall_next),
        .logical_next   (logical_next),
        .warn_time_next (warn_time_next),
        .status         (step_status),
        .warn           (step_warn),
        .first          (step_first)
    );

    // Clock state, updated once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_reg      <= '0;
            logical_reg   <= '0;
            warn_time_reg <= '0;
        end else if (advance) begin
            wall_reg      <= wall_next;
            logical_reg   <= logical_next;
            warn_time_reg <= warn_time_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_res_reg.out_wall_time  <= wall_next;
            out_res_reg.out_logical    <= OUT_LOGICAL_W'(logical_next);
            out_res_reg.out_node_id    <= node_id_reg;
            out_res_reg.skew_warning   <= step_warn;
            out_res_reg.first_reserved <= OUT_LOGICAL_W'(step_first);
            out_status_reg             <= step_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;
    assign m_tuser  = out_status_reg;

endmodule

[hdl/hlc_checker.sv]
`timescale 1ns / 1ps

module hlc_checker
    import hlc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    hlc_res_t res;
    assign res = m_tdata;

    // Stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Channel empty straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Reserved range only on an accepted reservation
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.first_reserved != '0 |-> m_tuser == ST_OK)
        else $error("reserved range with bad status");

    // Reserved range lies within the counter value that follows
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.first_reserved != '0 |-> res.out_logical >= res.first_reserved)
        else $error("counter below reserved range");

    // Skew warning only with no reserved range and status OK or stalled
    a_warn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.skew_warning |->
            res.first_reserved == '0 && (m_tuser == ST_OK || m_tuser == ST_STALLED))
        else $error("skew warning on wrong request");

endmodule

bind hybrid_logical_clock_unit hlc_checker u_hlc_checker (.*);

[dv/hybrid_logical_clock_unit_tb.sv]
`timescale 1ns / 1ps

module hybrid_logical_clock_unit_tb;
    import hlc_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam logic [TIME_W-1:0]        TIME_MAX    = '1;
    localparam logic [OUT_LOGICAL_W-1:0] LOGICAL_MAX =
        OUT_LOGICAL_W'((64'd1 << LOGICAL_WIDTH_DEF) - 64'd1);

    // Expected status and payload of one result
    typedef struct {
        hlc_status_t status;
        hlc_res_t    res;
    } clock_stamp_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NODE_ID;
    logic [TIME_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // phys_time, msg_wall_time, msg_logical,
                                            // req_time, req_count, zero pad
    logic [CMD_W-1:0]     s_tuser   = CMD_LOCAL;  // cmd
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // out_wall_time, out_logical, out_node_id,
                                     // skew_warning, first_reserved
    logic [STATUS_W-1:0]  m_tuser;   // status

    // Clock state and settings as the block should hold them
    logic [TIME_W-1:0]        clk_wall      = '0;
    logic [OUT_LOGICAL_W-1:0] clk_logical   = '0;
    logic [TIME_W-1:0]        clk_warn_time = '0;
    logic [NODE_W-1:0]        cfg_node      = '0;
    logic [TIME_W-1:0]        cfg_skew      = SKEW_LIMIT_RST;
    logic [TIME_W-1:0]        cfg_warn_gap  = WARN_INTERVAL_RST;

    clock_stamp_t pending_stamps[$];
    int unsigned  mismatch_count = 0;
    bit           src_gaps       = 1'b1;
    bit           sink_gaps      = 1'b1;
    bit           hold_go        = 1'b0;

    hybrid_logical_clock_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ---------------------------------------------------------------
    // Clock prediction
    // ---------------------------------------------------------------

    // Advance the predicted clock by one request and return its result
    function automatic clock_stamp_t step_clock(input hlc_cmd_t cmd, input hlc_req_t req);
        clock_stamp_t             r;
        logic [TIME_W-1:0]        lag;
        logic [TIME_W-1:0]        w;
        logic [TIME_W-1:0]        floor_t;
        logic [OUT_LOGICAL_W-1:0] cmsg;
        logic [OUT_LOGICAL_W-1:0] base;
        bit                       use_base;
        r.status             = ST_OK;
        r.res                = '0;
        case (cmd)
            CMD_LOCAL: begin
                if (req.phys_time > clk_wall) begin
                    clk_wall    = req.phys_time;
                    clk_logical = '0;
                end else begin
                    lag = clk_wall - req.phys_time;
                    if (lag > cfg_skew && req.phys_time >= clk_warn_time &&
                        req.phys_time - clk_warn_time > cfg_warn_gap) begin
                        r.res.skew_warning = 1'b1;
                        clk_warn_time      = req.phys_time;
                    end
                    if (clk_logical == LOGICAL_MAX) r.status = ST_STALLED;
                    else clk_logical++;
                end
            end
            CMD_MERGE: begin
                cmsg = (req.msg_logical > LOGICAL_MAX) ? LOGICAL_MAX : req.msg_logical;
                w = clk_wall;
                if (req.msg_wall_time > w) w = req.msg_wall_time;
                if (req.phys_time > w) w = req.phys_time;
                use_base = 1'b1;
                base     = '0;
                if (w == clk_wall && w == req.msg_wall_time)
                    base = (clk_logical > cmsg) ? clk_logical : cmsg;
                else if (w == clk_wall) base = clk_logical;
                else if (w == req.msg_wall_time) base = cmsg;
                else use_base = 1'b0;
                clk_wall = w;
                if (!use_base) begin
                    clk_logical = '0;
                end else if (base >= LOGICAL_MAX) begin
                    clk_logical = LOGICAL_MAX;
                    r.status    = ST_SATURATED;
                end else begin
                    clk_logical = base + 1'b1;
                end
            end
            CMD_RESERVE: begin
                floor_t = (req.phys_time > clk_wall) ? req.phys_time : clk_wall;
                if (req.req_count == '0 || req.req_time < floor_t) begin
                    r.status = ST_REJECTED;
                end else begin
                    if (req.req_time > clk_wall) begin
                        clk_wall    = req.req_time;
                        clk_logical = '0;
                    end
                    if (LOGICAL_MAX - clk_logical < OUT_LOGICAL_W'(req.req_count)) begin
                        r.status = ST_REJECTED;
                    end else begin
                        r.res.first_reserved = clk_logical + 1'b1;
                        clk_logical          = clk_logical + OUT_LOGICAL_W'(req.req_count);
                    end
                end
            end
            default: ;
        endcase
        r.res.out_wall_time = clk_wall;
        r.res.out_logical   = clk_logical;
        r.res.out_node_id   = cfg_node;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Value helpers
    // ---------------------------------------------------------------

    function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] d);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, d};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] time_sub(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] d);
        return (d > a) ? '0 : a - d;
    endfunction

    // Offset of random magnitude, below 2^40
    function automatic logic [TIME_W-1:0] rand_span();
        int unsigned k;
        logic [63:0] r;
        k = $urandom_range(0, 40);
        r = {$urandom, $urandom};
        return TIME_W'(r & ((64'd1 << k) - 64'd1));
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic hlc_req_t pack_request(input logic [TIME_W-1:0] phys,
                                              input logic [TIME_W-1:0] mwall,
                                              input logic [MSG_LOGICAL_W-1:0] mlog,
                                              input logic [TIME_W-1:0] rtime,
                                              input logic [COUNT_W-1:0] rcount);
        hlc_req_t req;
        req.phys_time     = phys;
        req.msg_wall_time = mwall;
        req.msg_logical   = mlog;
        req.req_time      = rtime;
        req.req_count     = rcount;
        return req;
    endfunction

    // Random request, mostly placed around the present clock state;
    // unused fields carry noise
    task automatic make_request(output hlc_cmd_t cmd, output hlc_req_t req);
        int unsigned              pick;
        logic [TIME_W-1:0]        floor_t;
        logic [OUT_LOGICAL_W-1:0] headroom;
        req = pack_request(rand_time(), rand_time(), $urandom, rand_time(),
                           COUNT_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 40) cmd = CMD_LOCAL;
        else if (pick < 70) cmd = CMD_MERGE;
        else if (pick < 95) cmd = CMD_RESERVE;
        else cmd = CMD_NONE;
        case (cmd)
            CMD_LOCAL: begin
                case ($urandom_range(0, 4))
                    0, 1: req.phys_time = time_add(clk_wall, rand_span() + 1'b1);
                    2: req.phys_time = clk_wall;
                    3: req.phys_time = time_sub(clk_wall, rand_span());
                    default: req.phys_time =
                        time_sub(clk_wall, time_add(cfg_skew, TIME_W'($urandom_range(0, 2))));
                endcase
            end
            CMD_MERGE: begin
                case ($urandom_range(0, 2))
                    0: req.msg_wall_time = clk_wall;
                    1: req.msg_wall_time = time_add(clk_wall, rand_span());
                    default: req.msg_wall_time = time_sub(clk_wall, rand_span());
                endcase
                case ($urandom_range(0, 3))
                    0: req.phys_time = clk_wall;
                    1: req.phys_time = req.msg_wall_time;
                    2: req.phys_time = time_add(clk_wall, rand_span());
                    default: req.phys_time = time_sub(clk_wall, rand_span());
                endcase
                case ($urandom_range(0, 5))
                    0: req.msg_logical = $urandom_range(0, 100);
                    1: req.msg_logical = clk_logical;
                    2: req.msg_logical = LOGICAL_MAX;
                    3: req.msg_logical = LOGICAL_MAX - $urandom_range(1, 3);
                    4: req.msg_logical = LOGICAL_MAX - $urandom_range(0, 200000);
                    default: ;
                endcase
            end
            CMD_RESERVE: begin
                case ($urandom_range(0, 2))
                    0: req.phys_time = clk_wall;
                    1: req.phys_time = time_sub(clk_wall, rand_span());
                    default: req.phys_time = time_add(clk_wall, rand_span());
                endcase
                floor_t = (req.phys_time > clk_wall) ? req.phys_time : clk_wall;
                case ($urandom_range(0, 4))
                    0, 1: req.req_time = floor_t;
                    2, 3: req.req_time = time_add(floor_t, rand_span());
                    default: req.req_time = time_sub(floor_t, rand_span() + 1'b1);
                endcase
                headroom = LOGICAL_MAX - clk_logical;
                case ($urandom_range(0, 7))
                    0: req.req_count = '0;
                    1: req.req_count = 16'd1;
                    2: req.req_count = '1;
                    3: begin
                        if (headroom < 32'hFFFF)
                            req.req_count = COUNT_W'(headroom + $urandom_range(0, 1));
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------

    // Offer one request, wait for it to be taken, then predict its result
    task automatic send_request(input hlc_cmd_t cmd, input hlc_req_t req);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - $bits(hlc_req_t)){1'b0}}, req};
        do @(posedge aclk); while (!s_tready);
        pending_stamps.push_back(step_clock(cmd, req));
    endtask

    // Stop offering and let every outstanding result come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_stamps.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers while the block is idle
    task automatic write_settings(input logic [TIME_W-1:0] node_raw,
                                  input logic [TIME_W-1:0] skew,
                                  input logic [TIME_W-1:0] warn_gap);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_NODE_ID;
        cfg_wdata <= node_raw;
        @(posedge aclk);
        cfg_index <= REG_SKEW_LIMIT;
        cfg_wdata <= skew;
        @(posedge aclk);
        cfg_index <= REG_WARN_INTERVAL;
        cfg_wdata <= warn_gap;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        cfg_node     = node_raw[NODE_W-1:0];
        cfg_skew     = skew;
        cfg_warn_gap = warn_gap;
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------

    // Ready with random bursts of back-pressure, or one long hold on request
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_go = 1'b0;
                m_tready <= 1'b1;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    clock_stamp_t want;
    hlc_res_t     got;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_stamps.size() == 0) begin
                $error("result with no request outstanding: status %0d data %0h",
                       m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_stamps.pop_front();
                got  = m_tdata;
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (got.out_wall_time !== want.res.out_wall_time) begin
                    $error("out_wall_time: expected %0h, got %0h",
                           want.res.out_wall_time, got.out_wall_time);
                    mismatch_count++;
                end
                if (got.out_logical !== want.res.out_logical) begin
                    $error("out_logical: expected %0h, got %0h",
                           want.res.out_logical, got.out_logical);
                    mismatch_count++;
                end
                if (got.out_node_id !== want.res.out_node_id) begin
                    $error("out_node_id: expected %0h, got %0h",
                           want.res.out_node_id, got.out_node_id);
                    mismatch_count++;
                end
                if (got.skew_warning !== want.res.skew_warning) begin
                    $error("skew_warning: expected %0b, got %0b",
                           want.res.skew_warning, got.skew_warning);
                    mismatch_count++;
                end
                if (got.first_reserved !== want.res.first_reserved) begin
                    $error("first_reserved: expected %0h, got %0h",
                           want.res.first_reserved, got.first_reserved);
                    mismatch_count++;
                end
            end
        end
    end

    // Give up after a long run of cycles with no transfer on either side
    initial begin : watchdog
        int unsigned quiet_run;
        quiet_run = 0;
        while (quiet_run < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_run = 0;
            else
                quiet_run++;
        end
        $display("hybrid_logical_clock_unit_tb: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Each command and corner, with the registers at their reset values
    task automatic test_directed_cases();
        send_request(CMD_LOCAL,   pack_request(0, 0, 0, 0, 0));          // no advance, tick
        send_request(CMD_LOCAL,   pack_request(1000, 0, 0, 0, 0));       // time passed
        send_request(CMD_LOCAL,   pack_request(1000, 0, 0, 0, 0));       // equal, tick
        send_request(CMD_MERGE,   pack_request(10, 1000, 5, 0, 0));      // local and msg tie
        send_request(CMD_MERGE,   pack_request(0, 2000, 7, 0, 0));       // message ahead
        send_request(CMD_MERGE,   pack_request(3000, 100, 9, 0, 0));     // physical ahead
        send_request(CMD_MERGE,   pack_request(0, 3000, LOGICAL_MAX, 0, 0)); // saturates
        send_request(CMD_LOCAL,   pack_request(3000, 0, 0, 0, 0));       // stalled at top
        send_request(CMD_RESERVE, pack_request(0, 0, 0, 3000, 1));       // no room
        send_request(CMD_RESERVE, pack_request(0, 0, 0, 2999, 1));       // too early
        send_request(CMD_RESERVE, pack_request(0, 0, 0, 5000, 0));       // zero count
        send_request(CMD_RESERVE, pack_request(0, 0, 0, 4000, 16'hFFFF)); // moves, claims all
        send_request(CMD_MERGE,   pack_request(50, 100, 9, 0, 0));       // local ahead
        send_request(CMD_MERGE,   pack_request(0, 4000, LOGICAL_MAX - 1, 0, 0)); // reaches top
        send_request(CMD_RESERVE, pack_request(100, 0, 0, 4000, 1));     // no room, no move
        send_request(CMD_LOCAL,   pack_request(20_000_000, 0, 0, 0, 0));
        send_request(CMD_LOCAL,   pack_request(6_000_000, 0, 0, 0, 0));  // warning
        send_request(CMD_LOCAL,   pack_request(6_000_000, 0, 0, 0, 0));  // rate limited
        send_request(CMD_LOCAL,   pack_request(11_000_001, 0, 0, 0, 0)); // warning again
        send_request(CMD_LOCAL,   pack_request(5_000_000, 0, 0, 0, 0));  // behind last warning
        send_request(CMD_NONE,    pack_request(rand_time(), rand_time(), $urandom,
                                               rand_time(), COUNT_W'($urandom)));
    endtask

    task automatic test_random_traffic(input int unsigned n_req,
                                       input logic [TIME_W-1:0] node_raw,
                                       input logic [TIME_W-1:0] skew,
                                       input logic [TIME_W-1:0] warn_gap,
                                       input bit with_gaps);
        hlc_cmd_t cmd;
        hlc_req_t req;
        write_settings(node_raw, skew, warn_gap);
        src_gaps  = with_gaps;
        sink_gaps = with_gaps;
        repeat (n_req) begin
            make_request(cmd, req);
            send_request(cmd, req);
        end
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        hlc_cmd_t cmd;
        hlc_req_t req;
        wait_idle();
        src_gaps = 1'b0;
        hold_go  = 1'b1;
        repeat (40) begin
            make_request(cmd, req);
            send_request(cmd, req);
        end
    endtask

    // All-ones and all-zeros fields; leaves the clock at its top value
    task automatic test_field_extremes();
        write_settings(TIME_MAX, '0, '0);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        send_request(CMD_LOCAL,   pack_request('0, '0, '0, '0, '0));
        send_request(CMD_LOCAL,   pack_request(TIME_MAX, '0, '0, '0, '0));
        send_request(CMD_MERGE,   pack_request(TIME_MAX, TIME_MAX, '1, '0, '0));
        send_request(CMD_RESERVE, pack_request(TIME_MAX, '0, '0, TIME_MAX, '1));
        send_request(CMD_LOCAL,   pack_request(TIME_MAX - 1'b1, '0, '0, '0, '0));
        send_request(CMD_NONE,    pack_request(TIME_MAX, TIME_MAX, '1, TIME_MAX, '1));
        send_request(CMD_RESERVE, pack_request('0, '0, '0, TIME_MAX, 16'd1));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_traffic(400, rand_time(), 100, 50, 1'b1);
        test_backpressure();
        test_random_traffic(400, TIME_W'(16'hFFFF), '0, '0, 1'b1);
        test_random_traffic(400, '0, TIME_MAX, TIME_MAX, 1'b1);
        test_random_traffic(400, rand_time(), $urandom_range(0, 1 << 24),
                            $urandom_range(0, 1 << 24), 1'b0);
        test_field_extremes();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("hybrid_logical_clock_unit_tb: clean");
        end else begin
            $display("hybrid_logical_clock_unit_tb: errors");
        end
        $finish;
    end

endmodule
